// ----- hdl/rpnh_pkg.sv -----
// rpnh_pkg: shared types and constants for the ray/plane nearest-hit core.
// Used by every module in hdl/; depends on nothing.
`default_nettype none

package rpnh_pkg;

    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OBJ_COUNT      = 256;

    localparam int DIST_W    = 31;
    localparam int IDX_W     = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIST_W-1:0] DIST_MAX     = '1;
    localparam logic [DIST_W-1:0] MIN_DIST_RST = DIST_W'(7);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_X    = 2'd0,
        REG_CAM_Y    = 2'd1,
        REG_CAM_Z    = 2'd2,
        REG_MIN_DIST = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DRAIN,
        ST_SETUP,
        ST_DIV,
        ST_UPD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic issue;
        logic sel_b;
    } t_mac_ctl;

    typedef struct packed {
        logic     in_ready;
        t_mac_ctl mac;
        logic     div_start;
        logic     trk_upd;
        logic     out_load;
    } t_ctl;

endpackage

`default_nettype wire

// ----- hdl/ray_plane_nearest_hit_core.sv -----
// ray_plane_nearest_hit_core: top level; sequencer, config registers, nearest-hit
// tracker and output register. Depends on rpnh_pkg, rpnh_mac, rpnh_div.
//
// Usage:
//  - Config channel (i_cfg_valid/o_cfg_ready, index, data) writes camera x/y/z and
//    min_distance; o_cfg_ready is always high. Write only while the core is idle.
//  - Input channel (i_in_valid/o_in_ready) takes one plane word per ray plane;
//    first_of_ray clears the tracker, last_of_ray produces one result word.
//  - Output channel (o_out_valid/i_out_ready) carries hit_found, hit_distance,
//    hit_index from an output register.
//  - One plane at a time: the products go through the shared multiplier, then a drain
//    step and a decision step. A plane that needs the divide then runs a range check on
//    the shared compare/subtract, which ends a saturated divide, else 31 quotient bits;
//    a last plane adds an emit step that waits for a free output register. o_in_ready
//    is high only between planes.
//  - A stalled receiver holds the result; the core accepts the next plane and only
//    waits at the end of a later last plane until the held word is taken.
//  - Synchronous active-low reset: camera 0, min_distance 7, tracker cleared,
//    no result pending.
`default_nettype none

module ray_plane_nearest_hit_core #(
    parameter int COORD_BITS = rpnh_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rpnh_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [rpnh_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [((COORD_BITS > rpnh_pkg::DIST_W) ?
                        COORD_BITS : rpnh_pkg::DIST_W)-1:0] i_cfg_data,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic signed [COORD_BITS-1:0]     i_dir_x,
    input  wire logic signed [COORD_BITS-1:0]     i_dir_y,
    input  wire logic signed [COORD_BITS-1:0]     i_dir_z,
    input  wire logic signed [COORD_BITS-1:0]     i_point_x,
    input  wire logic signed [COORD_BITS-1:0]     i_point_y,
    input  wire logic signed [COORD_BITS-1:0]     i_point_z,
    input  wire logic signed [COORD_BITS-1:0]     i_normal_x,
    input  wire logic signed [COORD_BITS-1:0]     i_normal_y,
    input  wire logic signed [COORD_BITS-1:0]     i_normal_z,
    input  wire logic [rpnh_pkg::IDX_W-1:0]       i_object_index,
    input  wire logic                             i_first_of_ray,
    input  wire logic                             i_last_of_ray,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic                                  o_hit_found,
    output logic [rpnh_pkg::DIST_W-1:0]           o_hit_distance,
    output logic [rpnh_pkg::IDX_W-1:0]            o_hit_index
);
    import rpnh_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int AW = 2 * CW + 3;

    t_state r_state;
    t_state n_state;
    t_ctl   w_ctl;

    logic signed [CW-1:0] r_cam [3];
    logic [DIST_W-1:0]    r_min_dist;

    logic signed [CW-1:0] w_pt  [3];
    logic signed [CW-1:0] w_dir [3];
    logic signed [CW-1:0] w_nrm [3];

    logic signed [DW-1:0] r_diff [3];
    logic signed [CW-1:0] r_dir  [3];
    logic signed [CW-1:0] r_nrm  [3];
    logic [IDX_W-1:0]     r_idx;
    logic                 r_last;

    logic [1:0]           r_k;
    logic                 r_half;
    logic                 r_hit_ok;

    logic signed [DW-1:0] w_op_x;
    logic signed [CW-1:0] w_op_y;
    logic signed [AW-1:0] w_acc_a;
    logic signed [AW-1:0] w_acc_b;

    logic                 w_accept;
    logic                 w_idx_ok;
    logic                 w_hit_ok;
    logic                 w_div_done;
    logic [DIST_W-1:0]    w_t;
    logic                 w_take;
    logic                 w_out_free;

    logic [DIST_W-1:0]    r_best_dist;
    logic [IDX_W-1:0]     r_best_idx;
    logic                 r_best_vld;

    logic                 r_out_valid;
    logic                 r_out_found;
    logic [DIST_W-1:0]    r_out_dist;
    logic [IDX_W-1:0]     r_out_idx;

    assign w_pt[0]  = i_point_x;
    assign w_pt[1]  = i_point_y;
    assign w_pt[2]  = i_point_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;
    assign w_nrm[0] = i_normal_x;
    assign w_nrm[1] = i_normal_y;
    assign w_nrm[2] = i_normal_z;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = w_ctl.in_ready;
    assign w_accept    = i_in_valid && w_ctl.in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cam[0]   <= '0;
            r_cam[1]   <= '0;
            r_cam[2]   <= '0;
            r_min_dist <= MIN_DIST_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_CAM_X:    r_cam[0]   <= i_cfg_data[CW-1:0];
                REG_CAM_Y:    r_cam[1]   <= i_cfg_data[CW-1:0];
                REG_CAM_Z:    r_cam[2]   <= i_cfg_data[CW-1:0];
                REG_MIN_DIST: r_min_dist <= i_cfg_data[DIST_W-1:0];
                default:      r_min_dist <= r_min_dist;
            endcase
        end
    end

    // input word capture; camera minus point formed on the way in
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < 3; i++) begin
                r_diff[i] <= DW'(r_cam[i]) - DW'(w_pt[i]);
                r_dir[i]  <= w_dir[i];
                r_nrm[i]  <= w_nrm[i];
            end
            r_idx  <= i_object_index;
            r_last <= i_last_of_ray;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid) n_state = ST_MUL;
            ST_MUL:   if (r_half && r_k == 2'd2) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_SETUP;
            ST_SETUP: n_state = w_hit_ok ? ST_DIV : ST_UPD;
            ST_DIV:   if (w_div_done) n_state = ST_UPD;
            ST_UPD:   n_state = r_last ? ST_EMIT : ST_IDLE;
            ST_EMIT:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_ctl           = '0;
        w_ctl.mac.sel_b = r_half;
        unique case (r_state)
            ST_IDLE: begin
                w_ctl.in_ready  = 1'b1;
                w_ctl.mac.clear = i_in_valid;
            end
            ST_MUL:   w_ctl.mac.issue = 1'b1;
            ST_SETUP: w_ctl.div_start = w_hit_ok;
            ST_UPD:   w_ctl.trk_upd   = 1'b1;
            ST_EMIT:  w_ctl.out_load  = w_out_free;
            default:  w_ctl.in_ready  = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_half  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_k    <= '0;
                r_half <= 1'b0;
            end else if (w_ctl.mac.issue) begin
                if (r_k == 2'd2) begin
                    r_k    <= '0;
                    r_half <= ~r_half;
                end else begin
                    r_k <= r_k + 2'd1;
                end
            end
        end
    end

    // a terms: (camera - point) * normal; b terms: dir * normal
    assign w_op_x = r_half ? DW'(r_dir[r_k]) : r_diff[r_k];
    assign w_op_y = r_nrm[r_k];

    rpnh_mac #(
        .CW (CW)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl.mac),
        .i_op_x  (w_op_x),
        .i_op_y  (w_op_y),
        .o_acc_a (w_acc_a),
        .o_acc_b (w_acc_b)
    );

    assign w_idx_ok = 32'(r_idx) < OBJ_COUNT;
    assign w_hit_ok = w_idx_ok && (w_acc_a != '0) && (w_acc_b != '0)
                      && (w_acc_a[AW-1] != w_acc_b[AW-1]);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SETUP) begin
            r_hit_ok <= w_hit_ok;
        end
    end

    rpnh_div #(
        .AW        (AW),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ctl.div_start),
        .i_num   (w_acc_a),
        .i_den   (w_acc_b),
        .o_done  (w_div_done),
        .o_quot  (w_t)
    );

    assign w_take = r_hit_ok && (w_t > r_min_dist)
                    && (!r_best_vld || (w_t < r_best_dist));

    // nearest-hit tracker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_dist <= DIST_MAX;
            r_best_idx  <= '0;
            r_best_vld  <= 1'b0;
        end else if ((w_accept && i_first_of_ray) || w_ctl.out_load) begin
            r_best_dist <= DIST_MAX;
            r_best_idx  <= '0;
            r_best_vld  <= 1'b0;
        end else if (w_ctl.trk_upd && w_take) begin
            r_best_dist <= w_t;
            r_best_idx  <= r_idx;
            r_best_vld  <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.out_load) begin
            r_out_found <= r_best_vld;
            r_out_dist  <= r_best_vld ? r_best_dist : DIST_MAX;
            r_out_idx   <= r_best_vld ? r_best_idx : '0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit_found    = r_out_found;
    assign o_hit_distance = r_out_dist;
    assign o_hit_index    = r_out_idx;

endmodule

`default_nettype wire

// ----- hdl/rpnh_mac.sv -----
// rpnh_mac: shared signed multiplier with registered product and two dot-product
// accumulators (a and b). Depends on rpnh_pkg.
`default_nettype none

module rpnh_mac #(
    parameter int CW = rpnh_pkg::COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire rpnh_pkg::t_mac_ctl    i_ctl,
    input  wire logic signed [CW:0]    i_op_x,
    input  wire logic signed [CW-1:0]  i_op_y,
    output logic signed [2*CW+2:0]     o_acc_a,
    output logic signed [2*CW+2:0]     o_acc_b
);
    import rpnh_pkg::*;

    localparam int PW = 2 * CW + 1;
    localparam int AW = PW + 2;

    logic signed [PW-1:0] w_prod;
    logic signed [PW-1:0] r_prod;
    logic                 r_pvld;
    logic                 r_psel;
    logic signed [AW-1:0] r_acc_a;
    logic signed [AW-1:0] r_acc_b;

    assign w_prod = i_op_x * i_op_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_prod <= w_prod;
            r_psel <= i_ctl.sel_b;
        end
        if (i_ctl.clear) begin
            r_acc_a <= '0;
            r_acc_b <= '0;
        end else if (r_pvld) begin
            if (r_psel) begin
                r_acc_b <= r_acc_b + AW'(r_prod);
            end else begin
                r_acc_a <= r_acc_a + AW'(r_prod);
            end
        end
    end

    assign o_acc_a = r_acc_a;
    assign o_acc_b = r_acc_b;

endmodule

`default_nettype wire

// ----- hdl/rpnh_div.sv -----
// rpnh_div: radix-2 restoring divider, t = floor(|num| * 2^FRAC / |den|), saturated
// to DIST_MAX. One shared compare/subtract, one quotient bit per cycle. Depends on rpnh_pkg.
`default_nettype none

module rpnh_div #(
    parameter int AW        = 2 * rpnh_pkg::COORD_BITS_DEF + 3,
    parameter int FRAC_BITS = rpnh_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic signed [AW-1:0]      i_num,
    input  wire logic signed [AW-1:0]      i_den,
    output logic                           o_done,
    output logic [rpnh_pkg::DIST_W-1:0]    o_quot
);
    import rpnh_pkg::*;

    localparam int NW    = AW + FRAC_BITS;
    localparam int CNT_W = $clog2(DIST_W);

    logic [AW-1:0]     w_num_u;
    logic [AW-1:0]     w_den_u;
    logic [AW-1:0]     w_mag_n;
    logic [AW-1:0]     w_mag_d;
    logic [NW-1:0]     w_wide;
    logic [AW:0]       w_cmp_a;
    logic [AW:0]       w_diff;
    logic              w_ge;

    logic              r_busy;
    logic              r_chk;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [AW-1:0]     r_rem;
    logic [AW-1:0]     r_den;
    logic [DIST_W-1:0] r_nlo;
    logic [DIST_W-1:0] r_q;
    logic              r_sat;

    assign w_num_u = i_num;
    assign w_den_u = i_den;
    assign w_mag_n = w_num_u[AW-1] ? (~w_num_u + AW'(1)) : w_num_u;
    assign w_mag_d = w_den_u[AW-1] ? (~w_den_u + AW'(1)) : w_den_u;
    assign w_wide  = {w_mag_n, {FRAC_BITS{1'b0}}};

    // check cycle: rem >= den means quotient needs more than DIST_W bits
    assign w_cmp_a = r_chk ? {1'b0, r_rem} : {r_rem, r_nlo[DIST_W-1]};
    assign w_ge    = w_cmp_a >= {1'b0, r_den};
    assign w_diff  = w_cmp_a - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_chk  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_chk  <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_chk) begin
                    r_chk <= 1'b0;
                    if (w_ge) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(DIST_W - 1)) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= AW'(w_wide[NW-1:DIST_W]);
            r_nlo <= w_wide[DIST_W-1:0];
            r_den <= w_mag_d;
            r_q   <= '0;
            r_sat <= 1'b0;
        end else if (r_busy) begin
            if (r_chk) begin
                r_sat <= w_ge;
            end else begin
                r_rem <= w_ge ? w_diff[AW-1:0] : w_cmp_a[AW-1:0];
                r_nlo <= {r_nlo[DIST_W-2:0], 1'b0};
                r_q   <= {r_q[DIST_W-2:0], w_ge};
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_sat ? DIST_MAX : r_q;

endmodule

`default_nettype wire

// ----- hdl/rpnh_chk.sv -----
// rpnh_chk: port-level assertions for ray_plane_nearest_hit_core, plus its bind.
// Depends on rpnh_pkg.
`default_nettype none

module rpnh_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          o_hit_found,
    input wire logic [rpnh_pkg::DIST_W-1:0]   o_hit_distance,
    input wire logic [rpnh_pkg::IDX_W-1:0]    o_hit_index
);
    import rpnh_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_hit_found) && $stable(o_hit_distance) && $stable(o_hit_index))
        else $error("result word changed while stalled");

    a_miss_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit_found |-> o_hit_distance == DIST_MAX && o_hit_index == '0)
        else $error("miss word carries distance or index");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken on back-to-back cycles");

endmodule

bind ray_plane_nearest_hit_core rpnh_chk u_rpnh_chk (.*);

`default_nettype wire

// ----- sim/tb_ray_plane_nearest_hit_core.sv -----
// tb_ray_plane_nearest_hit_core: self-checking bench for the ray/plane nearest-hit core.
// Runs a directed plane table, then random ray sequences under several camera settings.
// Expected results come from the typed table rows or a local nearest-hit tracker. Depends on rpnh_pkg.
module tb_ray_plane_nearest_hit_core;
    timeunit 1ns;
    timeprecision 1ps;

    import rpnh_pkg::*;

    localparam int FRAC          = FRAC_BITS_DEF;
    localparam int N_DIRECTED    = 22;
    localparam int N_PHASES      = 6;
    localparam int PHASE_PLANES  = 215;
    localparam int HOLD_CYCLES   = 500;
    localparam int DRAIN_CYCLES  = 64;
    localparam int STALL_LIMIT   = 4000;

    localparam logic [31:0] ZERO     = 32'h0000_0000;
    localparam logic [31:0] ONE      = 32'h0001_0000;
    localparam logic [31:0] NEG_ONE  = 32'hFFFF_0000;
    localparam logic [31:0] TWO      = 32'h0002_0000;
    localparam logic [31:0] THREE    = 32'h0003_0000;
    localparam logic [31:0] FIVE     = 32'h0005_0000;
    localparam logic [31:0] TEN      = 32'h000A_0000;
    localparam logic [31:0] TWENTY   = 32'h0014_0000;
    localparam logic [31:0] C_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN    = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] dir_x, dir_y, dir_z;
        logic [31:0] point_x, point_y, point_z;
        logic [31:0] normal_x, normal_y, normal_z;
        logic [7:0]  obj;
        logic        first, last;
    } plane_t;

    typedef struct packed {
        logic              found;
        logic [DIST_W-1:0] distance;
        logic [IDX_W-1:0]  idx;
    } hit_t;

    typedef struct packed {
        plane_t pl;
        logic   typed;
        hit_t   want;
    } vector_t;

    localparam hit_t NO_HIT = '{1'b0, DIST_MAX, 8'd0};

    // typed rows carry their result; the rest go through the tracker
    localparam vector_t DIRECTED [N_DIRECTED] = '{
        '{'{ZERO, ZERO, ONE, ZERO, ZERO, TEN, ZERO, ZERO, ZERO, 8'd3, 1'b1, 1'b1},
          1'b1, NO_HIT},
        '{'{ZERO, ZERO, ONE, ZERO, ZERO, TEN, ZERO, ZERO, ONE, 8'd5, 1'b1, 1'b1},
          1'b1, '{1'b1, 31'h000A_0000, 8'd5}},
        '{'{ZERO, ZERO, NEG_ONE, ZERO, ZERO, TEN, ZERO, ZERO, ONE, 8'd5, 1'b1, 1'b1},
          1'b1, NO_HIT},
        '{'{ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ZERO, ZERO, ONE, 8'd6, 1'b1, 1'b1},
          1'b1, NO_HIT},
        '{'{ZERO, ZERO, ONE, ZERO, ZERO, 32'd7, ZERO, ZERO, 32'd1, 8'd7, 1'b1, 1'b1},
          1'b1, NO_HIT},
        '{'{ZERO, ZERO, ONE, ZERO, ZERO, 32'd8, ZERO, ZERO, 32'd1, 8'd255, 1'b1, 1'b1},
          1'b1, '{1'b1, 31'd8, 8'd255}},
        '{'{ZERO, ZERO, 32'd1, ZERO, ZERO, C_MAX, ZERO, ZERO, ONE, 8'd9, 1'b1, 1'b1},
          1'b1, '{1'b1, DIST_MAX, 8'd9}},
        '{'{ZERO, ZERO, ONE, ZERO, ZERO, TEN, ZERO, ZERO, ONE, 8'd10, 1'b1, 1'b0},
          1'b0, '0},
        '{'{ZERO, ZERO, ONE, ZERO, ZERO, FIVE, ZERO, ZERO, ONE, 8'd11, 1'b0, 1'b0},
          1'b0, '0},
        '{'{ZERO, ZERO, ONE, ZERO, ZERO, FIVE, ZERO, ZERO, ONE, 8'd12, 1'b0, 1'b0},
          1'b0, '0},
        '{'{ZERO, ZERO, ONE, ZERO, ZERO, TWENTY, ZERO, ZERO, ONE, 8'd13, 1'b0, 1'b1},
          1'b0, '0},
        '{'{ONE, ZERO, ZERO, THREE, ZERO, ZERO, NEG_ONE, ZERO, ZERO, 8'd20, 1'b0, 1'b0},
          1'b0, '0},
        '{'{ONE, ZERO, ZERO, TEN, ZERO, ZERO, ONE, ZERO, ZERO, 8'd21, 1'b1, 1'b1},
          1'b0, '0},
        '{'{ONE, ZERO, ZERO, TWO, ZERO, ZERO, ONE, ZERO, ZERO, 8'd22, 1'b0, 1'b1},
          1'b0, '0},
        '{'{ZERO, ZERO, 32'd1, ZERO, ZERO, C_MAX, ZERO, ZERO, ONE, 8'd30, 1'b1, 1'b0},
          1'b0, '0},
        '{'{ZERO, ZERO, 32'd1, ZERO, ZERO, C_MAX, ZERO, ZERO, ONE, 8'd31, 1'b0, 1'b1},
          1'b0, '0},
        '{'{C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 8'd0, 1'b1, 1'b1},
          1'b0, '0},
        '{'{C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, 8'd128, 1'b1, 1'b1},
          1'b0, '0},
        '{'{C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, ONE, ONE, ONE, 8'd1, 1'b1, 1'b1},
          1'b0, '0},
        '{'{ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
            ALL_ONES, ALL_ONES, ALL_ONES, 8'd255, 1'b1, 1'b1},
          1'b0, '0},
        '{'{ZERO, ONE, ZERO, ZERO, TEN, ZERO, ONE, ZERO, ZERO, 8'd40, 1'b1, 1'b0},
          1'b0, '0},
        '{'{ZERO, NEG_ONE, ZERO, ZERO, TEN, ZERO, ZERO, ONE, ZERO, 8'd41, 1'b0, 1'b1},
          1'b1, NO_HIT}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    t_cfg_reg    i_cfg_index = REG_CAM_X;
    logic [31:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    plane_t      in_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_hit_found;
    logic [DIST_W-1:0] o_hit_distance;
    logic [IDX_W-1:0]  o_hit_index;

    // tracker state and configuration as the core should hold them
    logic [31:0]       cam_x = '0, cam_y = '0, cam_z = '0;
    logic [DIST_W-1:0] min_dist = MIN_DIST_RST;
    logic [DIST_W-1:0] best_dist = DIST_MAX;
    logic [IDX_W-1:0]  best_idx = '0;
    bit                best_valid = 1'b0;

    hit_t        expected_hits [$];
    hit_t        want_hit;
    int          planes_sent = 0;
    int          results_seen = 0;
    int          hits_seen = 0;
    int          mismatches = 0;
    int unsigned stall_cycles = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;

    always #6 i_clk = ~i_clk;

    ray_plane_nearest_hit_core dut (
        .i_clk,
        .i_rst_n,
        .i_cfg_valid,
        .o_cfg_ready,
        .i_cfg_index,
        .i_cfg_data,
        .i_in_valid,
        .o_in_ready,
        .i_dir_x        (in_word.dir_x),
        .i_dir_y        (in_word.dir_y),
        .i_dir_z        (in_word.dir_z),
        .i_point_x      (in_word.point_x),
        .i_point_y      (in_word.point_y),
        .i_point_z      (in_word.point_z),
        .i_normal_x     (in_word.normal_x),
        .i_normal_y     (in_word.normal_y),
        .i_normal_z     (in_word.normal_z),
        .i_object_index (in_word.obj),
        .i_first_of_ray (in_word.first),
        .i_last_of_ray  (in_word.last),
        .o_out_valid,
        .i_out_ready,
        .o_hit_found,
        .o_hit_distance,
        .o_hit_index
    );

    function automatic logic signed [95:0] wide(input logic [31:0] v);
        return 96'($signed(v));
    endfunction

    function automatic void reset_tracker();
        best_dist  = DIST_MAX;
        best_idx   = '0;
        best_valid = 1'b0;
    endfunction

    // advance the tracker by one plane; returns 1 when the plane ends a ray
    function automatic bit trace_plane(input plane_t p, output hit_t res);
        logic signed [95:0] a, b;
        logic [127:0]       q;
        logic [DIST_W-1:0]  t;
        res = '0;
        if (p.first)
            reset_tracker();
        a = (wide(cam_x) - wide(p.point_x)) * wide(p.normal_x)
          + (wide(cam_y) - wide(p.point_y)) * wide(p.normal_y)
          + (wide(cam_z) - wide(p.point_z)) * wide(p.normal_z);
        b = wide(p.dir_x) * wide(p.normal_x) + wide(p.dir_y) * wide(p.normal_y)
          + wide(p.dir_z) * wide(p.normal_z);
        if (a != 0 && b != 0 && a[95] != b[95]) begin
            q = (128'(a[95] ? -a : a) << FRAC) / 128'(b[95] ? -b : b);
            t = (q > 128'(DIST_MAX)) ? DIST_MAX : q[DIST_W-1:0];
            if (t > min_dist && (!best_valid || t < best_dist)) begin
                best_dist  = t;
                best_idx   = p.obj;
                best_valid = 1'b1;
            end
        end
        if (!p.last)
            return 1'b0;
        res = '{best_valid, best_valid ? best_dist : DIST_MAX, best_valid ? best_idx : 8'd0};
        reset_tracker();
        return 1'b1;
    endfunction

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return C_MIN;
                    1: return C_MAX;
                    2: return ZERO;
                    3: return ALL_ONES;
                    default: return 32'd1;
                endcase
            end
            1, 2: return $urandom();
            3, 4, 5: return (32'($urandom_range(0, 128)) - 32'd64) << 16;
            default: return 32'($urandom_range(0, 32'h007F_FFFF)) - 32'h0040_0000;
        endcase
    endfunction

    task automatic send_plane(input plane_t p, input bit typed, input hit_t want);
        hit_t got;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_word    <= p;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        planes_sent++;
        if (trace_plane(p, got))
            expected_hits.push_back(typed ? want : got);
    endtask

    task automatic drain_core();
        while (expected_hits.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (o_hit_found)
                hits_seen++;
            if (expected_hits.size() == 0) begin
                if (mismatches < 10)
                    $display("%0t: result word with nothing expected: found=%0b dist=%h idx=%0d",
                             $time, o_hit_found, o_hit_distance, o_hit_index);
                mismatches++;
            end else begin
                want_hit = expected_hits.pop_front();
                if (o_hit_found !== want_hit.found || o_hit_distance !== want_hit.distance
                    || o_hit_index !== want_hit.idx) begin
                    if (mismatches < 10)
                        $display("%0t: mismatch: want found=%0b dist=%h idx=%0d, %s%0b %s%h %s%0d",
                                 $time, want_hit.found, want_hit.distance, want_hit.idx,
                                 "got found=", o_hit_found, "dist=", o_hit_distance,
                                 "idx=", o_hit_index);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, expected_hits.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        plane_t      p;
        logic [31:0] ray_dx, ray_dy, ray_dz;
        logic [31:0] cfg_word [4];
        t_cfg_reg    reg_sel;
        int          len, in_phase;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIRECTED; k++)
            send_plane(DIRECTED[k].pl, DIRECTED[k].typed, DIRECTED[k].want);
        i_in_valid <= 1'b0;
        drain_core();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: cfg_word = '{ZERO, ZERO, ZERO, ZERO};
                1: cfg_word = '{C_MAX, C_MAX, C_MAX, ALL_ONES};
                2: cfg_word = '{C_MIN, C_MIN, C_MIN, 32'd7};
                default: cfg_word = '{rand_coord(), rand_coord(), rand_coord(),
                                      {1'($urandom), 31'($urandom_range(0, 32'h00FF_FFFF))}};
            endcase
            for (int k = 0; k < 4; k++) begin
                reg_sel = t_cfg_reg'(k);
                i_cfg_index <= reg_sel;
                i_cfg_data  <= cfg_word[k];
                i_cfg_valid <= 1'b1;
                do @(posedge i_clk); while (!o_cfg_ready);
                case (reg_sel)
                    REG_CAM_X: cam_x = cfg_word[k];
                    REG_CAM_Y: cam_y = cfg_word[k];
                    REG_CAM_Z: cam_z = cfg_word[k];
                    REG_MIN_DIST: min_dist = cfg_word[k][DIST_W-1:0];
                endcase
            end
            i_cfg_valid <= 1'b0;

            calm = (ph == 0);
            in_phase = 0;
            while (in_phase < PHASE_PLANES) begin
                len = $urandom_range(1, 6);
                ray_dx = rand_coord();
                ray_dy = rand_coord();
                ray_dz = rand_coord();
                for (int k = 0; k < len && in_phase < PHASE_PLANES; k++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        p.dir_x = rand_coord();
                        p.dir_y = rand_coord();
                        p.dir_z = rand_coord();
                    end else begin
                        p.dir_x = ray_dx;
                        p.dir_y = ray_dy;
                        p.dir_z = ray_dz;
                    end
                    if ($urandom_range(0, 19) == 0) begin
                        // plane through the camera
                        p.point_x = cam_x;
                        p.point_y = cam_y;
                        p.point_z = cam_z;
                    end else begin
                        p.point_x = rand_coord();
                        p.point_y = rand_coord();
                        p.point_z = rand_coord();
                    end
                    p.normal_x = rand_coord();
                    p.normal_y = rand_coord();
                    p.normal_z = rand_coord();
                    if ($urandom_range(0, 19) == 0)
                        p.normal_y = ZERO;
                    if ($urandom_range(0, 19) == 0) begin
                        p.normal_x = ZERO;
                        p.normal_z = ZERO;
                    end
                    p.obj   = 8'($urandom_range(0, 255));
                    p.first = (k == 0);
                    p.last  = (k == len - 1);
                    if ($urandom_range(0, 14) == 0) begin
                        p.first = 1'($urandom);
                        p.last  = 1'($urandom);
                    end
                    if (ph == 3 && in_phase == 100)
                        hold_req = 1'b1;
                    if (ph == N_PHASES - 1 && in_phase >= PHASE_PLANES - 150)
                        calm = 1'b1;
                    send_plane(p, 1'b0, '0);
                    in_phase++;
                end
            end
            i_in_valid <= 1'b0;
            drain_core();
        end

        $display("run: %0d planes under %0d camera/min-distance settings plus reset values",
                 planes_sent, N_PHASES);
        $display("run: %0d result words checked, %0d with a hit, %0d mismatches",
                 results_seen, hits_seen, mismatches);
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
